[hw/rtl/ledenc_pkg.sv]
// Shared types, constants and the tangent table for the addressable LED bit encoder.
// Depends on nothing; every RTL file of the encoder refers to it by scoped names.
package ledenc_pkg;

  // Bit results per pixel and the width of the counter that walks them.
  localparam int unsigned BIT_COUNT = 24;
  localparam int unsigned CNT_W     = 5;

  // Highest entry of the tangent table (tan 45 degrees is exactly 1.0).
  localparam int unsigned TABLE_TOP = 45;

  // Defaults for the top-level parameters.
  localparam int unsigned RESET_SLOTS_DEF = 50;
  localparam int unsigned MAX_ANGLE_DEF   = 45;

  // Field widths.
  localparam int unsigned ANGLE_W = 6;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned DUTY_W  = 8;
  localparam int unsigned REP_W   = 6;
  localparam int unsigned TAN_W   = 17;
  localparam int unsigned CFG_W   = 8;

  // Register reset values.
  localparam logic [ANGLE_W-1:0] BRIGHTNESS_RST = 6'd10;
  localparam logic               SCALE_EN_RST   = 1'b1;
  localparam logic [DUTY_W-1:0]  DUTY_ONE_RST   = 8'd60;
  localparam logic [DUTY_W-1:0]  DUTY_ZERO_RST  = 8'd30;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_BRIGHTNESS = 2'd0,
    REG_SCALE_EN   = 2'd1,
    REG_DUTY_ONE   = 2'd2,
    REG_DUTY_ZERO  = 2'd3
  } reg_idx_e;

  // One input word: a pixel.
  typedef struct packed {
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] blue;
    logic               last_pixel;
  } pixel_t;

  // One output word: a duty code and its slot count.
  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [REP_W-1:0]  repeat_res;
    logic              run_end;
  } result_t;

  // Settings the scaler needs.
  typedef struct packed {
    logic [ANGLE_W-1:0] brightness;
    logic               scale_enable;
  } scale_cfg_t;

  // Tangent of the angle in degrees, unsigned Q1.16.
  function automatic logic [TAN_W-1:0] tan_q16(input logic [ANGLE_W-1:0] angle);
    logic [TAN_W-1:0] t;
    case (angle)
      6'd0:  t = 17'd0;
      6'd1:  t = 17'd1143;
      6'd2:  t = 17'd2288;
      6'd3:  t = 17'd3434;
      6'd4:  t = 17'd4582;
      6'd5:  t = 17'd5733;
      6'd6:  t = 17'd6888;
      6'd7:  t = 17'd8046;
      6'd8:  t = 17'd9210;
      6'd9:  t = 17'd10379;
      6'd10: t = 17'd11555;
      6'd11: t = 17'd12738;
      6'd12: t = 17'd13930;
      6'd13: t = 17'd15130;
      6'd14: t = 17'd16339;
      6'd15: t = 17'd17560;
      6'd16: t = 17'd18792;
      6'd17: t = 17'd20036;
      6'd18: t = 17'd21293;
      6'd19: t = 17'd22565;
      6'd20: t = 17'd23853;
      6'd21: t = 17'd25156;
      6'd22: t = 17'd26478;
      6'd23: t = 17'd27818;
      6'd24: t = 17'd29178;
      6'd25: t = 17'd30559;
      6'd26: t = 17'd31964;
      6'd27: t = 17'd33392;
      6'd28: t = 17'd34846;
      6'd29: t = 17'd36327;
      6'd30: t = 17'd37837;
      6'd31: t = 17'd39378;
      6'd32: t = 17'd40951;
      6'd33: t = 17'd42559;
      6'd34: t = 17'd44204;
      6'd35: t = 17'd45888;
      6'd36: t = 17'd47614;
      6'd37: t = 17'd49384;
      6'd38: t = 17'd51202;
      6'd39: t = 17'd53070;
      6'd40: t = 17'd54991;
      6'd41: t = 17'd56969;
      6'd42: t = 17'd59008;
      6'd43: t = 17'd61113;
      6'd44: t = 17'd63287;
      default: t = 17'd65536;
    endcase
    return t;
  endfunction

endpackage

[hw/rtl/ledenc_scale.sv]
// Brightness scaler: input register, tangent lookup and three byte multipliers,
// and a register holding the 24-bit scaled color word. Depends on ledenc_pkg.
module ledenc_scale #(
  parameter int unsigned MAX_ANGLE = ledenc_pkg::MAX_ANGLE_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ledenc_pkg::scale_cfg_t cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  ledenc_pkg::pixel_t     in_data_i,
  output logic                   word_valid_o,
  input  logic                   word_ready_i,
  output logic [ledenc_pkg::BIT_COUNT-1:0] word_o,
  output logic                   word_last_o
);

  localparam int unsigned LIMIT = (MAX_ANGLE < ledenc_pkg::TABLE_TOP) ?
                                  MAX_ANGLE : ledenc_pkg::TABLE_TOP;
  localparam int unsigned PROD_W = ledenc_pkg::COLOR_W + ledenc_pkg::TAN_W;

  logic                   a_valid_q;
  ledenc_pkg::pixel_t     a_pix_q;
  logic                   b_valid_q;
  logic [ledenc_pkg::BIT_COUNT-1:0] b_word_q;
  logic                   b_last_q;
  logic                   a_move;
  logic [ledenc_pkg::ANGLE_W-1:0] angle;
  logic [ledenc_pkg::TAN_W-1:0]   tan_val;
  logic [PROD_W-1:0]      prod_g, prod_r, prod_b;
  logic [ledenc_pkg::BIT_COUNT-1:0] word_d;

  // Handshake between the two register stages.
  assign a_move     = a_valid_q && (!b_valid_q || word_ready_i);
  assign in_ready_o = !a_valid_q || a_move;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_pix_q <= in_data_i;
    end
  end

  // Saturate the angle and look up its tangent.
  assign angle   = (cfg_i.brightness > ledenc_pkg::ANGLE_W'(LIMIT)) ?
                   ledenc_pkg::ANGLE_W'(LIMIT) : cfg_i.brightness;
  assign tan_val = ledenc_pkg::tan_q16(angle);

  // Scale each byte; tan never exceeds 1.0, so the truncated product fits a byte.
  assign prod_g = PROD_W'(a_pix_q.green) * PROD_W'(tan_val);
  assign prod_r = PROD_W'(a_pix_q.red)   * PROD_W'(tan_val);
  assign prod_b = PROD_W'(a_pix_q.blue)  * PROD_W'(tan_val);

  always_comb begin
    if (cfg_i.scale_enable) begin
      word_d = {prod_g[23:16], prod_r[23:16], prod_b[23:16]};
    end else begin
      word_d = {a_pix_q.green, a_pix_q.red, a_pix_q.blue};
    end
  end

  // Scaled word register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (!b_valid_q || word_ready_i) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      b_word_q <= word_d;
      b_last_q <= a_pix_q.last_pixel;
    end
  end

  assign word_valid_o = b_valid_q;
  assign word_o       = b_word_q;
  assign word_last_o  = b_last_q;

endmodule

[hw/rtl/addressable_led_bit_encoder_core.sv]
// Top level of the addressable LED bit encoder: configuration registers, the scaler
// and the bit serializer with its output register. Depends on ledenc_pkg, ledenc_scale.

// Each accepted pixel produces 24 duty words, green first and most significant bit
// first, plus one reset word (duty 0 for RESET_SLOTS slots) after a pixel marked
// last. The serializer emits one word per cycle while its output register is free;
// the next pixel is accepted and scaled while the current one is still being sent,
// so with a ready sink the output runs without gaps. After a pixel is accepted into
// the input register, its first word passes through the scaled-word register, the
// serializer register and the output register.
// Configuration must only be written while the encoder is idle.
module addressable_led_bit_encoder_core #(
  parameter int unsigned RESET_SLOTS = ledenc_pkg::RESET_SLOTS_DEF,
  parameter int unsigned MAX_ANGLE   = ledenc_pkg::MAX_ANGLE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [ledenc_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  ledenc_pkg::pixel_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ledenc_pkg::result_t             out_data_o
);

  logic [ledenc_pkg::ANGLE_W-1:0] brightness_q;
  logic                           scale_en_q;
  logic [ledenc_pkg::DUTY_W-1:0]  duty_one_q;
  logic [ledenc_pkg::DUTY_W-1:0]  duty_zero_q;
  ledenc_pkg::scale_cfg_t         scale_cfg;

  logic                            word_valid;
  logic                            word_ready;
  logic [ledenc_pkg::BIT_COUNT-1:0] word;
  logic                            word_last;

  logic                            busy_q, busy_d;
  logic [ledenc_pkg::BIT_COUNT-1:0] sh_q, sh_d;
  logic [ledenc_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic                            last_q, last_d;
  logic                            out_valid_q, out_valid_d;
  ledenc_pkg::result_t             out_q, out_d;
  ledenc_pkg::result_t             res;
  logic                            out_free;
  logic                            emit;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= ledenc_pkg::BRIGHTNESS_RST;
      scale_en_q   <= ledenc_pkg::SCALE_EN_RST;
      duty_one_q   <= ledenc_pkg::DUTY_ONE_RST;
      duty_zero_q  <= ledenc_pkg::DUTY_ZERO_RST;
    end else if (cfg_we_i) begin
      case (ledenc_pkg::reg_idx_e'(cfg_idx_i))
        ledenc_pkg::REG_BRIGHTNESS: brightness_q <= cfg_data_i[ledenc_pkg::ANGLE_W-1:0];
        ledenc_pkg::REG_SCALE_EN:   scale_en_q   <= cfg_data_i[0];
        ledenc_pkg::REG_DUTY_ONE:   duty_one_q   <= cfg_data_i;
        ledenc_pkg::REG_DUTY_ZERO:  duty_zero_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign scale_cfg.brightness   = brightness_q;
  assign scale_cfg.scale_enable = scale_en_q;

  // Scaler front end.
  ledenc_scale #(
    .MAX_ANGLE(MAX_ANGLE)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (scale_cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .word_valid_o(word_valid),
    .word_ready_i(word_ready),
    .word_o      (word),
    .word_last_o (word_last)
  );

  // Word for the current serializer position.
  always_comb begin
    if (cnt_q < ledenc_pkg::CNT_W'(ledenc_pkg::BIT_COUNT)) begin
      res.duty       = sh_q[ledenc_pkg::BIT_COUNT-1] ? duty_one_q : duty_zero_q;
      res.repeat_res = ledenc_pkg::REP_W'(1);
      res.run_end    = !last_q && (cnt_q == ledenc_pkg::CNT_W'(ledenc_pkg::BIT_COUNT - 1));
    end else begin
      res.duty       = '0;
      res.repeat_res = ledenc_pkg::REP_W'(RESET_SLOTS);
      res.run_end    = 1'b1;
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign emit       = busy_q && out_free;
  assign word_ready = !busy_q || (emit && res.run_end);

  // Serializer next state.
  always_comb begin
    busy_d = busy_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    last_d = last_q;
    if (emit) begin
      sh_d  = {sh_q[ledenc_pkg::BIT_COUNT-2:0], 1'b0};
      cnt_d = cnt_q + ledenc_pkg::CNT_W'(1);
      if (res.run_end) begin
        busy_d = 1'b0;
      end
    end
    if (word_valid && word_ready) begin
      busy_d = 1'b1;
      sh_d   = word;
      cnt_d  = '0;
      last_d = word_last;
    end
  end

  // Output register next state.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_free) begin
      out_valid_d = busy_q;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    last_q <= last_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // The position counter never runs past the reset slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q <= ledenc_pkg::CNT_W'(ledenc_pkg::BIT_COUNT))
    else $error("serializer position beyond reset slot");

  // The reset slot is reached only for a pixel marked last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == ledenc_pkg::CNT_W'(ledenc_pkg::BIT_COUNT)) |-> last_q)
    else $error("reset slot reached for a pixel not marked last");

  // A new word is loaded only once the previous pixel has sent its final word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word_valid && word_ready && busy_q) |-> (emit && res.run_end))
    else $error("serializer reloaded before the run ended");

  // A word that spans several slots is always the low reset word ending the run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.repeat_res != ledenc_pkg::REP_W'(1)) |->
      (out_q.duty == '0 && out_q.run_end))
    else $error("multi-slot word is not a reset word");
`endif

endmodule

[verif/ledenc_checker.sv]
// Scoreboard for the addressable LED bit encoder: watches the configuration port, the pixel
// channel and the word channel, predicts the duty words of every accepted pixel and compares them.
// Depends on ledenc_pkg for the pixel and result word types and the register indexes.
`timescale 1ns / 1ps

module ledenc_checker #(
  parameter int unsigned RESET_SLOTS = ledenc_pkg::RESET_SLOTS_DEF,
  parameter int unsigned MAX_ANGLE   = ledenc_pkg::MAX_ANGLE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  ledenc_pkg::pixel_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  ledenc_pkg::result_t out_data_i,
  output logic                busy_o,
  output int unsigned         errors_o
);

  // The angle is limited by the parameter and by the top of the tangent table.
  localparam int unsigned ANGLE_CAP = (MAX_ANGLE < ledenc_pkg::TABLE_TOP) ?
                                      MAX_ANGLE : ledenc_pkg::TABLE_TOP;

  // Tangent of 0..45 degrees in unsigned Q1.16.
  localparam logic [16:0] TAN_Q16 [46] = '{
    17'd0,     17'd1143,  17'd2288,  17'd3434,  17'd4582,  17'd5733,  17'd6888,
    17'd8046,  17'd9210,  17'd10379, 17'd11555, 17'd12738, 17'd13930, 17'd15130,
    17'd16339, 17'd17560, 17'd18792, 17'd20036, 17'd21293, 17'd22565, 17'd23853,
    17'd25156, 17'd26478, 17'd27818, 17'd29178, 17'd30559, 17'd31964, 17'd33392,
    17'd34846, 17'd36327, 17'd37837, 17'd39378, 17'd40951, 17'd42559, 17'd44204,
    17'd45888, 17'd47614, 17'd49384, 17'd51202, 17'd53070, 17'd54991, 17'd56969,
    17'd59008, 17'd61113, 17'd63287, 17'd65536
  };

  // Shadow copy of the configuration registers.
  logic [5:0] angle_q;
  logic       scale_on_q;
  logic [7:0] duty_one_q;
  logic [7:0] duty_zero_q;

  // Duty words still owed by the encoder, oldest first.
  ledenc_pkg::result_t owed_duties[$];

  // Scale one color byte by the tangent and truncate; the result saturates at 255.
  function automatic logic [7:0] scale_color(input logic [7:0] c, input logic [16:0] t);
    logic [24:0] prod;
    prod = 25'(c) * 25'(t);
    return (prod[24:16] > 9'd255) ? 8'hFF : prod[23:16];
  endfunction

  // Work out the duty words of one pixel and queue them.
  task automatic encode_pixel(input ledenc_pkg::pixel_t px);
    logic [5:0]          angle;
    logic [16:0]         t;
    logic [23:0]         bits;
    ledenc_pkg::result_t w;
    angle = (angle_q > 6'(ANGLE_CAP)) ? 6'(ANGLE_CAP) : angle_q;
    t = TAN_Q16[angle];
    if (scale_on_q) begin
      bits = {scale_color(px.green, t), scale_color(px.red, t), scale_color(px.blue, t)};
    end else begin
      bits = {px.green, px.red, px.blue};
    end
    // Green first, most significant bit first.
    for (int k = 23; k >= 0; k--) begin
      w.duty       = bits[k] ? duty_one_q : duty_zero_q;
      w.repeat_res = ledenc_pkg::REP_W'(1);
      w.run_end    = !px.last_pixel && (k == 0);
      owed_duties.push_back(w);
    end
    // A last pixel closes the frame with the low reset stretch.
    if (px.last_pixel) begin
      w.duty       = '0;
      w.repeat_res = ledenc_pkg::REP_W'(RESET_SLOTS);
      w.run_end    = 1'b1;
      owed_duties.push_back(w);
    end
  endtask

  task automatic report_field(input string name, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // Track the registers, predict on every accepted pixel and check every accepted word.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    ledenc_pkg::result_t want;
    if (!rst_ni) begin
      angle_q     <= ledenc_pkg::BRIGHTNESS_RST;
      scale_on_q  <= ledenc_pkg::SCALE_EN_RST;
      duty_one_q  <= ledenc_pkg::DUTY_ONE_RST;
      duty_zero_q <= ledenc_pkg::DUTY_ZERO_RST;
      owed_duties.delete();
      busy_o      <= 1'b0;
      errors_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (ledenc_pkg::reg_idx_e'(cfg_idx_i))
          ledenc_pkg::REG_BRIGHTNESS: angle_q     <= cfg_data_i[5:0];
          ledenc_pkg::REG_SCALE_EN:   scale_on_q  <= cfg_data_i[0];
          ledenc_pkg::REG_DUTY_ONE:   duty_one_q  <= cfg_data_i;
          ledenc_pkg::REG_DUTY_ZERO:  duty_zero_q <= cfg_data_i;
          default: ;
        endcase
      end
      // A word leaving now cannot belong to a pixel accepted at this same edge.
      if (out_valid_i && out_ready_i) begin
        if (owed_duties.size() == 0) begin
          $display("%0t: unexpected word, expected none actual duty=%0d repeat=%0d end=%0b",
                   $time, out_data_i.duty, out_data_i.repeat_res, out_data_i.run_end);
          errors_o <= errors_o + 1;
        end else begin
          want = owed_duties.pop_front();
          if (want != out_data_i) begin
            errors_o <= errors_o + 1;
          end
          report_field("duty", 32'(want.duty), 32'(out_data_i.duty));
          report_field("repeat_res", 32'(want.repeat_res), 32'(out_data_i.repeat_res));
          report_field("run_end", 32'(want.run_end), 32'(out_data_i.run_end));
        end
      end
      if (in_valid_i && in_ready_i) begin
        encode_pixel(in_data_i);
      end
      busy_o <= (owed_duties.size() != 0);
    end
  end

endmodule

[verif/testbench.sv]
// Top of the encoder testbench: clock, reset, pixel and configuration stimulus, the
// word sink with its stalls, and the verdict. Depends on ledenc_pkg, ledenc_checker
// and addressable_led_bit_encoder_core.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PHASE_WORDS  = 70;
  localparam int unsigned RAND_PHASES  = 6;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [1:0]          cfg_idx_i;
  logic [7:0]          cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  ledenc_pkg::pixel_t  in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  ledenc_pkg::result_t out_data_o;

  logic        busy;
  int unsigned errors;
  logic        calm;
  logic        hold_req;
  logic        hold_done;

  addressable_led_bit_encoder_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  ledenc_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_i (out_data_o),
    .busy_o     (busy),
    .errors_o   (errors)
  );

  // 2 ns clock.
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Build a pixel word.
  function automatic ledenc_pkg::pixel_t pixel(input logic [7:0] g, input logic [7:0] r,
                                               input logic [7:0] b, input logic last);
    ledenc_pkg::pixel_t px;
    px.green      = g;
    px.red        = r;
    px.blue       = b;
    px.last_pixel = last;
    return px;
  endfunction

  // Random color byte, with the extremes picked more often than chance.
  function automatic logic [7:0] random_color();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offer one pixel, after an optional idle gap, and wait until it is taken.
  task automatic send_pixel(input ledenc_pkg::pixel_t px);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 99) < 21) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop offering and wait until every owed word has been delivered.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (busy);
    repeat (6) @(posedge clk_i);
  endtask

  // Write all four registers back to back; only legal while the encoder is idle.
  task automatic configure(input logic [7:0] angle, input logic [7:0] scale_on,
                           input logic [7:0] one, input logic [7:0] zero);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= ledenc_pkg::REG_BRIGHTNESS;
    cfg_data_i <= angle;
    @(posedge clk_i);
    cfg_idx_i  <= ledenc_pkg::REG_SCALE_EN;
    cfg_data_i <= scale_on;
    @(posedge clk_i);
    cfg_idx_i  <= ledenc_pkg::REG_DUTY_ONE;
    cfg_data_i <= one;
    @(posedge clk_i);
    cfg_idx_i  <= ledenc_pkg::REG_DUTY_ZERO;
    cfg_data_i <= zero;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Word sink: random stalls, none while calm, and one long hold-off on request.
  initial begin : sink
    int unsigned held;
    out_ready_i = 1'b0;
    hold_done   = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(posedge clk_i);
          held++;
        end
        hold_done = 1'b1;
      end else begin
        out_ready_i <= calm || ($urandom_range(0, 99) >= 21);
      end
    end
  end

  // Run limit.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("addressable_led_bit_encoder_core regression: fail");
    $finish;
  end

  // Stimulus and verdict.
  initial begin : stim
    logic [7:0] angle;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = ledenc_pkg::REG_BRIGHTNESS;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    rst_ni     = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset settings: 10 degrees, scaling on, duties 60 and 30.
    send_pixel(pixel(8'h00, 8'h00, 8'h00, 1'b0));
    send_pixel(pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_pixel(pixel(8'hFF, 8'h00, 8'hAA, 1'b1));
    send_pixel(pixel(8'h55, 8'hAA, 8'h0F, 1'b0));
    send_pixel(pixel(8'h80, 8'h01, 8'hF0, 1'b1));
    drain();

    // Zero angle blanks every color.
    configure(8'd0, 8'd1, 8'd60, 8'd30);
    send_pixel(pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_pixel(pixel(8'h12, 8'h34, 8'h56, 1'b1));
    drain();

    // Exactly 45 degrees passes colors through; duty codes at their extremes.
    configure(8'd45, 8'd1, 8'd255, 8'd0);
    send_pixel(pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));
    send_pixel(pixel(8'hFE, 8'h01, 8'h80, 1'b1));
    send_pixel(pixel(8'h00, 8'hFF, 8'h00, 1'b0));
    drain();

    // Angle above the limit saturates to 45.
    configure(8'd63, 8'd1, 8'd0, 8'd255);
    send_pixel(pixel(8'hFF, 8'h7F, 8'h01, 1'b0));
    send_pixel(pixel(8'hC3, 8'h3C, 8'h99, 1'b1));
    drain();

    // Scaling off sends raw bytes whatever the angle.
    configure(8'd44, 8'd0, 8'd255, 8'd1);
    send_pixel(pixel(8'hA5, 8'h5A, 8'hFF, 1'b1));
    send_pixel(pixel(8'h01, 8'h02, 8'h03, 1'b0));
    drain();

    // Smallest nonzero angle.
    configure(8'd1, 8'd1, 8'd60, 8'd30);
    send_pixel(pixel(8'hFF, 8'hFF, 8'hFF, 1'b1));
    drain();

    // Random phases, each under fresh random settings.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 4))
        0:       angle = 8'd0;
        1:       angle = 8'd45;
        2:       angle = 8'd63;
        3:       angle = 8'($urandom_range(0, 255));
        default: angle = 8'($urandom_range(0, 63));
      endcase
      configure(angle, ($urandom_range(0, 3) != 0) ? 8'($urandom_range(1, 255)) : 8'd0,
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      if (ph == 1) hold_req <= 1'b1;
      if (ph == 2) calm <= 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_pixel(pixel(random_color(), random_color(), random_color(),
                         $urandom_range(0, 7) == 0));
      end
      drain();
      calm <= 1'b0;
    end

    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("addressable_led_bit_encoder_core regression: pass");
    end else begin
      $display("addressable_led_bit_encoder_core regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/ledenc_pkg.sv
hw/rtl/ledenc_scale.sv
hw/rtl/addressable_led_bit_encoder_core.sv
verif/ledenc_checker.sv
verif/testbench.sv
